/* rtl/core/wpm_pkg.sv */
// Shared constants, codes and types of the word permutation window matcher.
`timescale 1ns / 1ps

package wpm_pkg;

    // Sizing
    localparam int MAX_WORDS    = 8;
    localparam int MAX_WORD_LEN = 8;
    localparam int POS_BITS     = 16;
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 64;
    localparam int SLOT_W       = 3;
    localparam int LEN_W        = 4;
    localparam int OUT_W        = 16;
    localparam int FUNC_W       = 2;
    localparam int WIN_DEPTH    = MAX_WORDS * MAX_WORD_LEN;
    localparam int WIN_IDX_W    = $clog2(WIN_DEPTH);
    localparam int TOTAL_W      = $clog2(WIN_DEPTH + 1);
    localparam int CNT_W        = $clog2(MAX_WORDS + 1);

    // Stream packing: tdata = {pad, text_byte, word_value, word_index}, tuser = func
    localparam int IN_DATA_W    = 80;
    localparam int IN_USER_W    = FUNC_W;
    localparam int SLOT_LSB     = 0;
    localparam int WORD_LSB     = SLOT_LSB + SLOT_W;
    localparam int BYTE_LSB     = WORD_LSB + WORD_W;

    // Function codes carried in tuser
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT = 1'd1;

    // Byte 0 is the newest byte of the text
    typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] t_window;
    typedef logic [MAX_WORDS-1:0][WORD_W-1:0] t_table;

    // Effective geometry after saturation
    typedef struct packed {
        logic               active;
        logic [LEN_W-1:0]   wl;
        logic [LEN_W-1:0]   wc;
        logic [TOTAL_W-1:0] total;
    } t_cfg;

    // Pending window check
    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] start;
    } t_chk;

endpackage

/* rtl/core/wpm_front.sv */
// Input stage: config registers, word table, byte window, position counter.
`timescale 1ns / 1ps

module wpm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_chk_move,
    input  logic [wpm_pkg::FUNC_W-1:0]    i_func,
    input  logic [wpm_pkg::SLOT_W-1:0]    i_slot,
    input  logic [wpm_pkg::WORD_W-1:0]    i_word,
    input  logic [wpm_pkg::BYTE_W-1:0]    i_byte,
    input  logic                          i_cfg_we,
    input  logic [wpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wpm_pkg::LEN_W-1:0]     i_cfg_data,
    output wpm_pkg::t_window              o_window,
    output wpm_pkg::t_table               o_table,
    output wpm_pkg::t_cfg                 o_cfg,
    output wpm_pkg::t_chk                 o_chk
);
    import wpm_pkg::*;

    logic [LEN_W-1:0]    r_word_len;
    logic [LEN_W-1:0]    r_word_count;
    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] n_pos;
    t_chk                r_chk;
    t_chk                n_chk;
    t_window             r_window;
    t_table              r_table;
    t_cfg                cfg;
    logic [2*LEN_W-1:0]  prod;

    // Saturated geometry
    always_comb begin
        cfg.active = (r_word_len != '0) && (r_word_count != '0);
        cfg.wl     = (r_word_len > LEN_W'(MAX_WORD_LEN)) ? LEN_W'(MAX_WORD_LEN) : r_word_len;
        cfg.wc     = (r_word_count > LEN_W'(MAX_WORDS)) ? LEN_W'(MAX_WORDS) : r_word_count;
        prod       = cfg.wl * cfg.wc;
        cfg.total  = prod[TOTAL_W-1:0];
    end

    // Position update and window check request
    always_comb begin
        n_pos       = r_pos;
        n_chk.valid = 1'b0;
        n_chk.start = '0;
        case (i_func)
            FUNC_TEXT: begin
                if (r_pos != '1) begin
                    n_pos       = r_pos + 1'b1;
                    n_chk.valid = cfg.active && (n_pos >= POS_BITS'(cfg.total));
                    n_chk.start = OUT_W'(n_pos - POS_BITS'(cfg.total));
                end
            end
            FUNC_RESTART: n_pos = '0;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_len   <= LEN_W'(1);
            r_word_count <= LEN_W'(1);
            r_pos        <= '0;
            r_chk        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WORD_LEN:   r_word_len   <= i_cfg_data;
                    CFG_WORD_COUNT: r_word_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_pos <= n_pos;
                r_chk <= n_chk;
            end else if (i_chk_move) begin
                r_chk.valid <= 1'b0;
            end
        end
    end

    // Payload: byte shift window and word table
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_func == FUNC_TEXT)) begin
            r_window <= {r_window[WIN_DEPTH-2:0], i_byte};
        end
        if (i_accept && (i_func == FUNC_LOAD)) begin
            r_table[i_slot] <= i_word;
        end
    end

    assign o_window = r_window;
    assign o_table  = r_table;
    assign o_cfg    = cfg;
    assign o_chk    = r_chk;

endmodule

/* rtl/core/wpm_match.sv */
// Compare stage: cuts the window into chunks and checks them against the table as a multiset.
`timescale 1ns / 1ps

module wpm_match (
    input  wpm_pkg::t_window i_window,
    input  wpm_pkg::t_table  i_table,
    input  wpm_pkg::t_cfg    i_cfg,
    input  wpm_pkg::t_chk    i_chk,
    output logic             o_hit
);
    import wpm_pkg::*;

    logic [WORD_W-1:0] chunk [MAX_WORDS];
    logic [WORD_W-1:0] mask;
    logic [CNT_W-1:0]  nc    [MAX_WORDS];
    logic [CNT_W-1:0]  nw    [MAX_WORDS];
    logic              all_ok;
    int                ago;

    // Chunk k byte b sits total-1-(k*wl+b) bytes back from the newest
    always_comb begin
        mask = '0;
        for (int b = 0; b < MAX_WORD_LEN; b++) begin
            if (LEN_W'(b) < i_cfg.wl) mask[BYTE_W*b +: BYTE_W] = '1;
        end
        for (int k = 0; k < MAX_WORDS; k++) begin
            chunk[k] = '0;
            for (int b = 0; b < MAX_WORD_LEN; b++) begin
                ago = int'(i_cfg.total) - 1 - (k * int'(i_cfg.wl) + b);
                if ((LEN_W'(k) < i_cfg.wc) && (LEN_W'(b) < i_cfg.wl)) begin
                    chunk[k][BYTE_W*b +: BYTE_W] = i_window[ago[WIN_IDX_W-1:0]];
                end
            end
        end
    end

    // Occurrence counts per chunk: among chunks and among table words
    always_comb begin
        all_ok = 1'b1;
        for (int i = 0; i < MAX_WORDS; i++) begin
            nc[i] = '0;
            nw[i] = '0;
            for (int j = 0; j < MAX_WORDS; j++) begin
                if (LEN_W'(j) < i_cfg.wc) begin
                    nc[i] = nc[i] + CNT_W'(chunk[j] == chunk[i]);
                    nw[i] = nw[i] + CNT_W'((i_table[j] & mask) == chunk[i]);
                end
            end
            if ((LEN_W'(i) < i_cfg.wc) && (nc[i] != nw[i])) all_ok = 1'b0;
        end
    end

    assign o_hit = i_chk.valid && all_ok;

endmodule

/* rtl/core/word_permutation_window_match.sv */
// Timing: a text beat is stored as a pending check, and its match_start beat is then registered in the output register.
// Throughput: one input beat per cycle while tready is high; load and restart beats produce no output.
// The input/state registers feed the chunk compare, which loads the output register;
// tready drops only while a pending check waits behind a stalled result.
// Reset: synchronous, active low; clears position, pipeline valids, word_len=1,
// word_count=1. The word table holds nothing defined until loaded.
`timescale 1ns / 1ps

module word_permutation_window_match (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: word_index[2:0], word_value[66:3], text_byte[74:67], zero pad[79:75]
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [wpm_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // tuser: func[1:0]
    input  logic [wpm_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    // tdata: match_start[15:0]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [wpm_pkg::OUT_W-1:0]     o_m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wpm_pkg::LEN_W-1:0]     i_cfg_data
);
    import wpm_pkg::*;

    t_window          window;
    t_table           table_q;
    t_cfg             cfg;
    t_chk             chk;
    logic             hit;
    logic             out_free;
    logic             accept;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_start;

    // Handshake: compare stage drains whenever the output slot frees up
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = out_free || !chk.valid;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    wpm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_chk_move  (out_free),
        .i_func      (i_s_axis_tuser[FUNC_W-1:0]),
        .i_slot      (i_s_axis_tdata[SLOT_LSB +: SLOT_W]),
        .i_word      (i_s_axis_tdata[WORD_LSB +: WORD_W]),
        .i_byte      (i_s_axis_tdata[BYTE_LSB +: BYTE_W]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_window    (window),
        .o_table     (table_q),
        .o_cfg       (cfg),
        .o_chk       (chk)
    );

    wpm_match u_match (
        .i_window (window),
        .i_table  (table_q),
        .i_cfg    (cfg),
        .i_chk    (chk),
        .o_hit    (hit)
    );

    // Output register: valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= hit;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (out_free && hit) begin
            r_out_start <= chk.start;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_start;

endmodule

/* rtl/core/wpm_checker.sv */
// Port-level checks of the matcher, bound to the top level.
`timescale 1ns / 1ps

module wpm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [wpm_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [wpm_pkg::OUT_W-1:0]     o_m_axis_tdata
);
    import wpm_pkg::*;

    logic text_beat;
    assign text_beat = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == FUNC_TEXT);

    // No result beat pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A fresh result comes from an earlier text beat, through the pending check and the output register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(text_beat, 2))
        else $error("result without a text beat two cycles before");

    // Stalled result keeps valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result data changed while stalled");

endmodule

bind word_permutation_window_match wpm_checker u_wpm_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the word permutation window matcher.
`timescale 1ns / 1ps

module tb;
    import wpm_pkg::*;

    // Code the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int unsigned POS_MAX     = (1 << POS_BITS) - 1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned LONG_TEXT   = 300;
    localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_B = 8'h62;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [IN_USER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data = '0;

    // Predicted block state
    logic [BYTE_W-1:0] window_model [WIN_DEPTH] = '{default: '0};
    logic [WORD_W-1:0] table_model [MAX_WORDS] = '{default: '0};
    int unsigned       text_pos_model = 0;
    logic [LEN_W-1:0]  word_len_model = 4'd1;
    logic [LEN_W-1:0]  word_count_model = 4'd1;

    // Expected match starts, oldest first
    logic [OUT_W-1:0] match_start_q [$];
    logic [OUT_W-1:0] expected_start;

    bit          idle_on = 1'b0;
    int unsigned error_count = 0;
    int unsigned matches_checked = 0;
    int unsigned beats_sent = 0;
    int unsigned text_sent = 0;
    int unsigned loads_sent = 0;
    int unsigned restarts_sent = 0;
    int unsigned phases_run = 0;
    int unsigned cycle_count = 0;

    word_permutation_window_match uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("word_permutation_window_match: mismatch");
            $finish;
        end
    end

    // Output backpressure
    always @(posedge clk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 6);
    end

    // Result checker
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (match_start_q.size() == 0) begin
                $error("match_start: expected none, actual %0d", m_tdata);
                error_count++;
            end else begin
                expected_start = match_start_q.pop_front();
                matches_checked++;
                if (m_tdata !== expected_start) begin
                    $error("match_start: expected %0d, actual %0d", expected_start, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // Multiset compare of the window's chunks against the first wc table words
    function automatic bit window_is_permutation(int unsigned wl, int unsigned wc);
        logic [WORD_W-1:0] chunks [MAX_WORDS];
        logic [WORD_W-1:0] mask;
        int unsigned total;
        int unsigned n_chunk;
        int unsigned n_word;
        total = wl * wc;
        if (wl >= MAX_WORD_LEN)
            mask = '1;
        else
            mask = (64'd1 << (8 * wl)) - 64'd1;
        for (int k = 0; k < wc; k++) begin
            chunks[k] = '0;
            for (int b = 0; b < wl; b++)
                chunks[k][8*b +: 8] = window_model[total - 1 - (k * wl + b)];
        end
        for (int i = 0; i < wc; i++) begin
            n_chunk = 0;
            n_word = 0;
            for (int j = 0; j < wc; j++) begin
                if (chunks[j] == chunks[i])
                    n_chunk++;
                if ((table_model[j] & mask) == chunks[i])
                    n_word++;
            end
            if (n_chunk != n_word)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Shift one text byte in and predict its report
    task automatic predict_text_byte(input logic [BYTE_W-1:0] text);
        int unsigned wl;
        int unsigned wc;
        int unsigned total;
        for (int i = WIN_DEPTH - 1; i > 0; i--)
            window_model[i] = window_model[i-1];
        window_model[0] = text;
        if (text_pos_model >= POS_MAX)
            return;
        text_pos_model++;
        if (word_len_model == 0 || word_count_model == 0)
            return;
        wl = (word_len_model > MAX_WORD_LEN) ? MAX_WORD_LEN : word_len_model;
        wc = (word_count_model > MAX_WORDS) ? MAX_WORDS : word_count_model;
        total = wl * wc;
        if (text_pos_model < total)
            return;
        if (window_is_permutation(wl, wc))
            match_start_q.insert(match_start_q.size(), OUT_W'(text_pos_model - total));
    endtask

    // One input beat; valid stays high on return so back-to-back beats need no toggle
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                             input logic [WORD_W-1:0] word, input logic [BYTE_W-1:0] text);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        data[SLOT_LSB +: SLOT_W] = slot;
        data[WORD_LSB +: WORD_W] = word;
        data[BYTE_LSB +: BYTE_W] = text;
        while (idle_on && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (func)
            FUNC_LOAD: begin
                if (slot < MAX_WORDS)
                    table_model[slot] = word;
                loads_sent++;
            end
            FUNC_TEXT: begin
                predict_text_byte(text);
                text_sent++;
            end
            FUNC_RESTART: begin
                text_pos_model = 0;
                window_model = '{default: '0};
                restarts_sent++;
            end
            default: ;
        endcase
        if (func != FUNC_SPARE)
            beats_sent++;
    endtask

    task automatic send_text(input logic [BYTE_W-1:0] text);
        send_item(FUNC_TEXT, SLOT_W'($urandom), {$urandom, $urandom}, text);
    endtask

    task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] word);
        send_item(FUNC_LOAD, slot, word, BYTE_W'($urandom));
    endtask

    task automatic send_restart();
        send_item(FUNC_RESTART, SLOT_W'($urandom), {$urandom, $urandom}, BYTE_W'($urandom));
    endtask

    task automatic send_spare();
        send_item(FUNC_SPARE, SLOT_W'($urandom), {$urandom, $urandom}, BYTE_W'($urandom));
    endtask

    // Register write once the block has drained
    task automatic set_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [LEN_W-1:0] value);
        s_tvalid <= 1'b0;
        while (match_start_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == CFG_WORD_LEN)
            word_len_model = value;
        else
            word_count_model = value;
    endtask

    task automatic set_geometry(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] cnt);
        set_register(CFG_WORD_LEN, len);
        set_register(CFG_WORD_COUNT, cnt);
    endtask

    // Reset geometry is one one-byte word
    task automatic test_default_geometry();
        send_load(3'd0, {$urandom, 24'($urandom), CHAR_A});
        send_text(CHAR_A);
        send_text(8'h00);
        send_text(CHAR_A);
        send_spare();
        send_restart();
        send_text(CHAR_A);
    endtask

    // A zero length or count never reports
    task automatic test_zero_geometry();
        set_register(CFG_WORD_LEN, 4'd0);
        send_text(CHAR_A);
        send_text(CHAR_A);
        set_geometry(4'd1, 4'd0);
        send_text(CHAR_A);
        send_text(CHAR_A);
    endtask

    // Length above the limit acts as eight bytes; all-ones word
    task automatic test_oversized_length();
        set_geometry(4'd15, 4'd1);
        send_load(3'd0, '1);
        send_restart();
        repeat (MAX_WORD_LEN) send_text(8'hFF);
    endtask

    // Two equal words must both be present
    task automatic test_duplicate_words();
        set_geometry(4'd2, 4'd2);
        send_load(3'd0, {$urandom, 16'($urandom), CHAR_B, CHAR_A});
        send_load(3'd1, {$urandom, 16'($urandom), CHAR_B, CHAR_A});
        send_restart();
        repeat (3) begin
            send_text(CHAR_A);
            send_text(CHAR_B);
        end
    endtask

    // Random byte, from a two-letter alphabet when narrow
    function automatic logic [BYTE_W-1:0] pick_byte(input bit narrow);
        if (narrow)
            return $urandom_range(1) ? CHAR_B : CHAR_A;
        return BYTE_W'($urandom);
    endfunction

    // One geometry, a word list, then text built mostly from shuffled concatenations
    task automatic run_search_phase();
        logic [LEN_W-1:0]  len_cfg;
        logic [LEN_W-1:0]  cnt_cfg;
        logic [WORD_W-1:0] words [MAX_WORDS];
        logic [WORD_W-1:0] pool [MAX_WORDS];
        logic [WORD_W-1:0] low_mask;
        logic [BYTE_W-1:0] text;
        int unsigned order [MAX_WORDS];
        int unsigned wl;
        int unsigned wc;
        int unsigned distinct;
        int unsigned flip_at;
        int unsigned j;
        int unsigned tmp;
        bit narrow;
        bit corrupt;
        if (phases_run == 0) begin
            len_cfg = 4'd8;
            cnt_cfg = 4'd8;
        end else if (phases_run == 1) begin
            len_cfg = 4'd15;
            cnt_cfg = 4'd15;
        end else begin
            len_cfg = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15))
                                               : LEN_W'($urandom_range(1, 8));
            cnt_cfg = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15))
                                               : LEN_W'($urandom_range(1, 8));
        end
        // quiet stretch with no idling on either side
        idle_on = !(phases_run >= 6 && phases_run < 11);
        phases_run++;
        if ($urandom_range(1))
            set_geometry(len_cfg, cnt_cfg);
        else begin
            set_register(CFG_WORD_COUNT, cnt_cfg);
            set_register(CFG_WORD_LEN, len_cfg);
        end
        wl = (len_cfg == 0) ? 2 : ((len_cfg > MAX_WORD_LEN) ? MAX_WORD_LEN : len_cfg);
        wc = (cnt_cfg == 0) ? 2 : ((cnt_cfg > MAX_WORDS) ? MAX_WORDS : cnt_cfg);
        low_mask = (wl >= MAX_WORD_LEN) ? '1 : ((64'd1 << (8 * wl)) - 64'd1);
        narrow = $urandom_range(1);

        // word list with duplicates; bytes past the length are junk
        distinct = $urandom_range(1, wc);
        for (int d = 0; d < distinct; d++)
            for (int b = 0; b < MAX_WORD_LEN; b++)
                pool[d][8*b +: 8] = pick_byte(narrow);
        for (int s = 0; s < MAX_WORDS; s++) begin
            words[s] = (pool[$urandom_range(distinct - 1)] & low_mask)
                     | ({$urandom, $urandom} & ~low_mask);
            if (s < wc || $urandom_range(1))
                send_load(SLOT_W'(s), words[s]);
        end
        if ($urandom_range(1))
            send_restart();

        repeat ($urandom_range(2, 6)) begin
            tmp = $urandom_range(99);
            if (tmp < 6)
                send_restart();
            else if (tmp < 10)
                send_spare();
            else if (tmp < 15) begin
                // reload: same compared bytes, new junk above them
                j = $urandom_range(MAX_WORDS - 1);
                words[j] = (words[j] & low_mask) | ({$urandom, $urandom} & ~low_mask);
                send_load(SLOT_W'(j), words[j]);
            end
            repeat ($urandom_range(0, 3)) send_text(pick_byte(narrow));
            for (int k = 0; k < wc; k++)
                order[k] = k;
            for (int k = wc - 1; k > 0; k--) begin
                j = $urandom_range(k);
                tmp = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            corrupt = ($urandom_range(99) < 15);
            flip_at = $urandom_range(wl * wc - 1);
            for (int k = 0; k < wc; k++)
                for (int b = 0; b < wl; b++) begin
                    text = words[order[k]][8*b +: 8];
                    if (corrupt && flip_at == k * wl + b)
                        text ^= BYTE_W'($urandom_range(1, 255));
                    send_text(text);
                end
        end
    endtask

    task automatic test_random_streams();
        int unsigned start_beats;
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_ITEMS)
            run_search_phase();
        idle_on = 1'b1;
    endtask

    // A long text without restart: positions climb well past one byte
    task automatic test_long_text();
        set_geometry(4'd2, 4'd1);
        send_load(3'd0, {$urandom, 16'($urandom), CHAR_B, CHAR_A});
        send_restart();
        for (int unsigned n = 0; n < LONG_TEXT; n++)
            send_text(CHAR_A + BYTE_W'($urandom_range(2)));
        send_restart();
        send_text(CHAR_A);
        send_text(CHAR_B);
    endtask

    initial begin
        idle_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_geometry();
        test_zero_geometry();
        test_oversized_length();
        test_duplicate_words();
        test_random_streams();
        test_long_text();

        // drain
        s_tvalid <= 1'b0;
        while (match_start_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d beats: %0d text bytes, %0d loads, %0d restarts, %0d phases",
                 beats_sent, text_sent, loads_sent, restarts_sent, phases_run);
        $display("Checked %0d match_start beats, %0d errors", matches_checked, error_count);
        if (error_count == 0)
            $display("word_permutation_window_match: match");
        else
            $display("word_permutation_window_match: mismatch");
        $finish;
    end

endmodule
